@@ hw/rtl/assert_macros.svh @@
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/xs96_pkg.sv @@
package xs96_pkg;

  // request codes
  typedef enum logic [2:0] {
    REQ_DRAW       = 3'd0,
    REQ_DRAW_FRAC  = 3'd1,
    REQ_FILL       = 3'd2,
    REQ_CACHED     = 3'd3,
    REQ_CACHED_FRAC = 3'd4,
    REQ_BUILD      = 3'd5,
    REQ_READ_PERM  = 3'd6,
    REQ_NONE       = 3'd7
  } req_t;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_CACHE  = 2'd1;
  localparam logic [1:0] ST_NO_PERM   = 2'd2;

  // config register indexes
  localparam logic [1:0] CFG_CACHE_COUNT = 2'd0;
  localparam logic [1:0] CFG_PERM_COUNT  = 2'd1;

  localparam logic [31:0] SEED_FIRST  = 32'd123456789;
  localparam logic [31:0] SEED_SECOND = 32'd362436069;
  localparam logic [31:0] SEED_THIRD  = 32'd521288629;

  localparam logic [10:0] CACHE_COUNT_RST = 11'd1024;
  localparam logic [8:0]  PERM_COUNT_RST  = 9'd256;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] entry_index;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] value;
    logic [28:0] fraction;
    logic [1:0]  status;
  } out_beat_t;

endpackage

@@ hw/rtl/xs96_ram.sv @@
// Simple dual-port RAM: one write port, one registered read port.
module xs96_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/xs96_gen.sv @@
// xorshift96 state; word shows the value that a step produces.
module xs96_gen import xs96_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  output logic [31:0] word
);

  logic [31:0] first_r, second_r, third_r;
  logic [31:0] a0, a1, a2;

  always_comb begin
    a0   = first_r ^ (first_r << 16);
    a1   = a0 ^ (a0 >> 5);
    a2   = a1 ^ (a1 << 1);
    word = a2 ^ second_r ^ third_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= SEED_FIRST;
      second_r <= SEED_SECOND;
      third_r  <= SEED_THIRD;
    end else if (step) begin
      first_r  <= second_r;
      second_r <= third_r;
      third_r  <= word;
    end
  end

endmodule

@@ hw/rtl/xs96_mod.sv @@
// Bit-serial remainder of a 32-bit word by a narrow divisor.
module xs96_mod #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] rem
);

  logic [31:0]   num_r;
  logic [DW-1:0] den_r, rem_r;
  logic [5:0]    cnt_r;
  logic [DW:0]   sh, diff;

  always_comb begin
    sh   = {rem_r, num_r[31]};
    diff = sh - {1'b0, den_r};
  end

  assign busy = (cnt_r != 6'd0);
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 6'd0;
    end else if (start) begin
      cnt_r <= 6'd32;
    end else if (busy) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy) begin
      num_r <= {num_r[30:0], 1'b0};
      rem_r <= (sh >= {1'b0, den_r}) ? diff[DW-1:0] : sh[DW-1:0];
    end
  end

endmodule

@@ hw/rtl/xorshift96_random_unit_top.sv @@
// xorshift96 random unit. One request at a time; one result beat per request.
// A fill writes one cache RAM entry per generated word. A build writes the
// identity table, then swaps from the top entry down; each swap waits on the
// bit-serial remainder unit and goes through the one read and one write port
// of the permutation RAM.
module xorshift96_random_unit_top import xs96_pkg::*; #(
  parameter int CACHE_DEPTH = 1024,
  parameter int PERM_DEPTH  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);

`include "assert_macros.svh"

  localparam int CW  = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CLW = $clog2(CACHE_DEPTH + 1);
  localparam int PW  = $clog2(PERM_DEPTH);
  localparam int PLW = $clog2(PERM_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_FILL, S_CREAD, S_PREAD, S_PINIT,
    S_PDRAW, S_PRDI, S_PDIV, S_PRDJ, S_PWRJ
  } state_t;

  state_t state_r;
  in_beat_t in_r;
  logic [10:0] cache_count_r;
  logic [8:0]  perm_count_r;
  logic        filled_r, built_r;
  logic [CW-1:0]  cursor_r;
  logic [CLW-1:0] cache_len_r, ck_r;
  logic [PLW-1:0] perm_len_r, pk_r;
  logic [PW-1:0]  i_r, j_r, ti_r;
  logic           out_valid_r;
  out_beat_t      out_r;

  logic [CLW-1:0] cache_len_nxt, cur_inc;
  logic [PLW-1:0] perm_len_nxt;
  logic [CW-1:0]  cursor_nxt;
  logic           gen_step;
  logic [31:0]    gen_word;
  logic           div_start, div_busy;
  logic [PW-1:0]  div_rem;
  logic           c_we, p_we;
  logic [CW-1:0]  c_waddr, c_raddr;
  logic [31:0]    c_rdata;
  logic [PW-1:0]  p_waddr, p_wdata, p_raddr, p_rdata;
  logic           perm_ok;

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // length clamps and cursor pre-increment
  always_comb begin
    if (cache_count_r == 11'd0) begin
      cache_len_nxt = CLW'(1);
    end else if (32'(cache_count_r) > 32'(CACHE_DEPTH)) begin
      cache_len_nxt = CLW'(CACHE_DEPTH);
    end else begin
      cache_len_nxt = CLW'(cache_count_r);
    end
    if (perm_count_r == 9'd0) begin
      perm_len_nxt = PLW'(1);
    end else if (32'(perm_count_r) > 32'(PERM_DEPTH)) begin
      perm_len_nxt = PLW'(PERM_DEPTH);
    end else begin
      perm_len_nxt = PLW'(perm_count_r);
    end
    cur_inc    = CLW'(cursor_r) + CLW'(1);
    cursor_nxt = (cur_inc >= cache_len_r) ? '0 : cur_inc[CW-1:0];
    perm_ok    = built_r && (32'(in_r.entry_index) < 32'(perm_len_r));
  end

  // memory and unit controls
  always_comb begin
    gen_step  = 1'b0;
    div_start = 1'b0;
    c_we      = 1'b0;
    c_waddr   = ck_r[CW-1:0];
    c_raddr   = cursor_nxt;
    p_we      = 1'b0;
    p_waddr   = pk_r[PW-1:0];
    p_wdata   = pk_r[PW-1:0];
    p_raddr   = PW'(in_r.entry_index);
    unique case (state_r)
      S_DISP: begin
        gen_step = (in_r.req_type == REQ_DRAW) || (in_r.req_type == REQ_DRAW_FRAC);
      end
      S_FILL: begin
        gen_step = 1'b1;
        c_we     = 1'b1;
      end
      S_PINIT: begin
        p_we = 1'b1;
      end
      S_PDRAW: begin
        gen_step  = 1'b1;
        div_start = 1'b1;
        p_raddr   = i_r;
      end
      S_PDIV: begin
        p_raddr = div_rem;
      end
      S_PRDJ: begin
        p_we    = 1'b1;
        p_waddr = i_r;
        p_wdata = p_rdata;
      end
      S_PWRJ: begin
        p_we    = 1'b1;
        p_waddr = j_r;
        p_wdata = ti_r;
      end
      default: begin
      end
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_count_r <= CACHE_COUNT_RST;
      perm_count_r  <= PERM_COUNT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CACHE_COUNT) begin
        cache_count_r <= cfg_wdata;
      end else if (cfg_index == CFG_PERM_COUNT) begin
        perm_count_r <= cfg_wdata[8:0];
      end
    end
  end

  // request sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      filled_r    <= 1'b0;
      built_r     <= 1'b0;
      cursor_r    <= '0;
      cache_len_r <= '0;
      perm_len_r  <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            in_r    <= in_data;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          unique case (req_t'(in_r.req_type))
            REQ_DRAW, REQ_DRAW_FRAC: begin
              out_r       <= '{value: gen_word, fraction: gen_word[28:0], status: ST_OK};
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
            REQ_FILL: begin
              out_r       <= '{value: '0, fraction: '0, status: ST_OK};
              cache_len_r <= cache_len_nxt;
              ck_r        <= '0;
              state_r     <= S_FILL;
            end
            REQ_CACHED, REQ_CACHED_FRAC: begin
              if (!filled_r) begin
                out_r       <= '{value: '0, fraction: '0, status: ST_NO_CACHE};
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end else begin
                cursor_r <= cursor_nxt;
                state_r  <= S_CREAD;
              end
            end
            REQ_BUILD: begin
              out_r      <= '{value: '0, fraction: '0, status: ST_OK};
              perm_len_r <= perm_len_nxt;
              pk_r       <= '0;
              state_r    <= S_PINIT;
            end
            REQ_READ_PERM: begin
              if (!perm_ok) begin
                out_r       <= '{value: '0, fraction: '0, status: ST_NO_PERM};
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end else begin
                state_r <= S_PREAD;
              end
            end
            REQ_NONE: begin
              out_r       <= '{value: '0, fraction: '0, status: ST_OK};
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          endcase
        end
        S_FILL: begin
          ck_r <= ck_r + CLW'(1);
          if (ck_r == cache_len_r - CLW'(1)) begin
            filled_r    <= 1'b1;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_CREAD: begin
          out_r       <= '{value: c_rdata, fraction: c_rdata[28:0], status: ST_OK};
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_PREAD: begin
          out_r       <= '{value: 32'(p_rdata), fraction: 29'(p_rdata), status: ST_OK};
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_PINIT: begin
          pk_r <= pk_r + PLW'(1);
          if (pk_r == perm_len_r - PLW'(1)) begin
            i_r <= pk_r[PW-1:0];
            if (perm_len_r == PLW'(1)) begin
              built_r     <= 1'b1;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_PDRAW;
            end
          end
        end
        S_PDRAW: begin
          state_r <= S_PRDI;
        end
        S_PRDI: begin
          ti_r    <= p_rdata;
          state_r <= S_PDIV;
        end
        S_PDIV: begin
          if (!div_busy) begin
            j_r     <= div_rem;
            state_r <= S_PRDJ;
          end
        end
        S_PRDJ: begin
          state_r <= S_PWRJ;
        end
        S_PWRJ: begin
          if (i_r == PW'(1)) begin
            built_r     <= 1'b1;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            i_r     <= i_r - PW'(1);
            state_r <= S_PDRAW;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  xs96_gen u_gen (
    .clk  (clk),
    .rst_n(rst_n),
    .step (gen_step),
    .word (gen_word)
  );

  xs96_mod #(.DW(PW)) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(gen_word),
    .divisor (i_r),
    .busy    (div_busy),
    .rem     (div_rem)
  );

  xs96_ram #(.WIDTH(32), .DEPTH(CACHE_DEPTH)) u_cache_ram (
    .clk  (clk),
    .we   (c_we),
    .waddr(c_waddr),
    .wdata(gen_word),
    .raddr(c_raddr),
    .rdata(c_rdata)
  );

  xs96_ram #(.WIDTH(PW), .DEPTH(PERM_DEPTH)) u_perm_ram (
    .clk  (clk),
    .we   (p_we),
    .waddr(p_waddr),
    .wdata(p_wdata),
    .raddr(p_raddr),
    .rdata(p_rdata)
  );

  // error beats carry zero payload
  `ASSERT_IMPL(a_err_zero, out_valid && (out_data.status != ST_OK), out_data.value == 32'd0)
  // swap partner always below the current top entry
  `ASSERT_IMPL(a_rem_range, (state_r == S_PDIV) && !div_busy, div_rem < i_r)
  // once filled, the cache stays filled
  `ASSERT_NEXT(a_filled_keep, filled_r, filled_r)

endmodule

@@ verif/xs96_checker.sv @@
module xs96_checker import xs96_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_beat_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  output int          mismatches,
  output int          beats_owed,
  output int          beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CACHE_WORDS = 1024;
  localparam int PERM_WORDS  = 256;

  // shadow copy of the generator, stores and length registers
  logic [31:0] gen_a, gen_b, gen_c;
  logic [10:0] cache_reg;
  logic [8:0]  perm_reg;
  logic [31:0] cache_mem [CACHE_WORDS];
  logic [31:0] perm_mem [PERM_WORDS];
  logic        have_cache, have_perm;
  int          cursor, cache_fill_len, perm_built_len;
  out_beat_t   owed_q [$];

  function automatic logic [31:0] xs96_next();
    logic [31:0] a;
    a = gen_a;
    a ^= a << 16;
    a ^= a >> 5;
    a ^= a << 1;
    gen_a = gen_b;
    gen_b = gen_c;
    gen_c = a ^ gen_a ^ gen_b;
    return gen_c;
  endfunction

  function automatic int clamp_len(int v, int depth);
    if (v == 0) return 1;
    if (v > depth) return depth;
    return v;
  endfunction

  // one request in, its result beat out; updates the shadow state
  function automatic out_beat_t serve_request(in_beat_t b);
    out_beat_t   r;
    logic [31:0] j, t;
    r = '0;
    case (req_t'(b.req_type))
      REQ_DRAW, REQ_DRAW_FRAC: r.value = xs96_next();
      REQ_FILL: begin
        cache_fill_len = clamp_len(int'(cache_reg), CACHE_WORDS);
        for (int i = 0; i < cache_fill_len; i++) cache_mem[i] = xs96_next();
        have_cache = 1'b1;
      end
      REQ_CACHED, REQ_CACHED_FRAC: begin
        if (!have_cache) begin
          r.status = ST_NO_CACHE;
        end else begin
          cursor++;
          if (cursor >= cache_fill_len) cursor = 0;
          r.value = cache_mem[cursor];
        end
      end
      REQ_BUILD: begin
        perm_built_len = clamp_len(int'(perm_reg), PERM_WORDS);
        for (int i = 0; i < perm_built_len; i++) perm_mem[i] = i;
        // cyclic shuffle from the top down
        for (int i = perm_built_len - 1; i != 0; i--) begin
          j = xs96_next() % i;
          t = perm_mem[i];
          perm_mem[i] = perm_mem[j];
          perm_mem[j] = t;
        end
        have_perm = 1'b1;
      end
      REQ_READ_PERM: begin
        if (!have_perm || int'(b.entry_index) >= perm_built_len) r.status = ST_NO_PERM;
        else r.value = perm_mem[b.entry_index];
      end
      default: ;
    endcase
    r.fraction = r.value[28:0];
    return r;
  endfunction

  assign beats_owed = owed_q.size();

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      gen_a <= SEED_FIRST;
      gen_b <= SEED_SECOND;
      gen_c <= SEED_THIRD;
      cache_reg <= CACHE_COUNT_RST;
      perm_reg <= PERM_COUNT_RST;
      have_cache <= 1'b0;
      have_perm <= 1'b0;
      cursor <= 0;
      cache_fill_len <= 0;
      perm_built_len <= 0;
      owed_q.delete();
      mismatches <= 0;
      beats_checked <= 0;
    end else begin
      if (cfg_we && cfg_index == CFG_CACHE_COUNT) cache_reg <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_PERM_COUNT) perm_reg <= cfg_wdata[8:0];
      if (in_valid && !in_stall) owed_q.push_back(serve_request(in_data));
      // result beat against the oldest expectation
      if (out_valid && !out_stall) begin
        beats_checked <= beats_checked + 1;
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_data);
          mismatches <= mismatches + 1;
        end else begin
          want = owed_q.pop_front();
          if (want.value !== out_data.value || want.fraction !== out_data.fraction ||
              want.status !== out_data.status) begin
            $display("%0t: result mismatch expected value %h frac %h status %0d,",
                     $time, want.value, want.fraction, want.status);
            $display("    got value %h frac %h status %0d",
                     out_data.value, out_data.fraction, out_data.status);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

@@ verif/tb_xorshift96_random_unit_top.sv @@
module tb_xorshift96_random_unit_top;
  import xs96_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_wdata = '0;

  int mismatches, beats_owed, beats_checked;
  int items_sent = 0;
  int perm_len_now = 256;
  bit no_idle = 1'b0;
  bit in_taken = 1'b0, out_taken = 1'b0;
  int stall_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  xorshift96_random_unit_top DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  xs96_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata, .mismatches, .beats_owed, .beats_checked
  );

  // handshake flags seen at the last rising edge
  always @(posedge clk) begin
    in_taken  <= in_valid && !in_stall;
    out_taken <= out_valid && !out_stall;
  end

  // result-side back-pressure, redrawn after every beat
  always @(negedge clk) begin
    int left;
    left = stall_left;
    if (out_taken) left = no_idle ? 0 : $urandom_range(0, 6);
    out_stall <= (left != 0);
    stall_left <= (left != 0) ? left - 1 : 0;
  end

  task automatic send(req_t r, logic [7:0] idx);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.req_type = r;
    in_data.entry_index = idx;
    in_valid = 1'b1;
    do @(negedge clk); while (!in_taken);
    items_sent++;
  endtask

  // drain, let the block settle, then program both lengths
  task automatic set_lengths(logic [10:0] cache_n, logic [10:0] perm_n);
    in_valid = 1'b0;
    wait (beats_owed == 0);
    repeat (8) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_CACHE_COUNT;
    cfg_wdata = cache_n;
    @(negedge clk);
    cfg_index = CFG_PERM_COUNT;
    cfg_wdata = perm_n;
    @(negedge clk);
    cfg_we = 1'b0;
    perm_len_now = (perm_n[8:0] == 0) ? 1 : (perm_n[8:0] > 256) ? 256 : perm_n[8:0];
  endtask

  function automatic req_t pick_req();
    int roll;
    roll = $urandom_range(0, 999);
    if (roll < 90) return REQ_DRAW;
    if (roll < 180) return REQ_DRAW_FRAC;
    if (roll < 210) return REQ_FILL;
    if (roll < 400) return REQ_CACHED;
    if (roll < 580) return REQ_CACHED_FRAC;
    if (roll < 600) return (perm_len_now > 64 && roll >= 585) ? REQ_NONE : REQ_BUILD;
    if (roll < 970) return REQ_READ_PERM;
    return REQ_NONE;
  endfunction

  task automatic random_items(int n);
    logic [7:0] idx;
    for (int k = 0; k < n; k++) begin
      if (k % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      idx = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, perm_len_now - 1))
                                       : 8'($urandom_range(0, 255));
      send(pick_req(), idx);
      // let the pipeline run completely dry now and then
      if (k == n / 2) begin
        in_valid = 1'b0;
        wait (beats_owed == 0);
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // error cases first, then each request at the reset lengths
    send(REQ_CACHED, 8'h00);
    send(REQ_CACHED_FRAC, 8'h00);
    send(REQ_READ_PERM, 8'h00);
    send(REQ_NONE, 8'hff);
    send(REQ_DRAW, 8'h00);
    send(REQ_DRAW_FRAC, 8'hff);
    send(REQ_FILL, 8'h00);
    send(REQ_CACHED, 8'h00);
    send(REQ_CACHED_FRAC, 8'h00);
    send(REQ_BUILD, 8'h00);
    send(REQ_READ_PERM, 8'h00);
    send(REQ_READ_PERM, 8'hff);
    send(REQ_READ_PERM, 8'h55);
    send(REQ_READ_PERM, 8'haa);

    // refill that wraps the cursor on the next read, short table with out-of-range reads
    set_lengths(11'd3, 11'd2);
    send(REQ_FILL, 8'h00);
    send(REQ_CACHED, 8'h00);
    send(REQ_BUILD, 8'h00);
    send(REQ_READ_PERM, 8'h01);
    send(REQ_READ_PERM, 8'h02);
    send(REQ_BUILD, 8'h00);
    send(REQ_READ_PERM, 8'h00);

    // spare register index must be ignored
    in_valid = 1'b0;
    wait (beats_owed == 0);
    repeat (8) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_SPARE;
    cfg_wdata = 11'h7ff;
    @(negedge clk);
    cfg_we = 1'b0;

    random_items(250);
    set_lengths(11'd1, 11'd2);
    random_items(250);
    set_lengths(11'd0, 11'd0);
    random_items(200);
    set_lengths(11'h7ff, 11'h1ff);
    random_items(150);
    set_lengths(11'd1024, 11'd256);
    random_items(150);
    for (int p = 0; p < 4; p++) begin
      set_lengths(11'($urandom_range(1, 40)), 11'($urandom_range(1, 40)));
      random_items(200);
    end

    in_valid = 1'b0;
    wait (beats_owed == 0);
    repeat (20) @(negedge clk);
    $display("Ran %0d requests of all types over nine length settings, %0d results checked.",
             items_sent, beats_checked);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #60ms;
    $display("Run timed out with %0d results outstanding.", beats_owed);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/xs96_pkg.sv
hw/rtl/xs96_ram.sv
hw/rtl/xs96_gen.sv
hw/rtl/xs96_mod.sv
hw/rtl/xorshift96_random_unit_top.sv
verif/xs96_checker.sv
verif/tb_xorshift96_random_unit_top.sv
